// ===== src/bmpscl_pkg.sv =====
// shared constants and types for the bmp row unpacker and nearest-neighbor scaler
package bmpscl_pkg;

    // fixed field widths
    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 3;
    localparam int BPP_W        = 3;
    localparam int ORG_X_W      = 9;
    localparam int ORG_Y_W      = 8;
    localparam int BYTE_W       = 8;
    localparam int RGB_W        = 24;
    localparam int POS_W        = 13;
    localparam int S_TDATA_W    = 8;
    localparam int M_FIELDS_W   = RGB_W + 2 * POS_W;
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

    // image height is saturated to this many rows
    localparam int HEIGHT_LIMIT = 4096;

    // parameter defaults
    localparam int DEF_MAX_SOURCE_WIDTH = 4096;
    localparam int DEF_SCREEN_WIDTH     = 480;
    localparam int DEF_SCREEN_HEIGHT    = 240;

    // register value that selects 32-bit pixels
    localparam logic [BPP_W-1:0] BPP_FOUR = 3'd4;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH    = 3'd0,
        CFG_SOURCE_HEIGHT   = 3'd1,
        CFG_ROWS_TOP_DOWN   = 3'd2,
        CFG_BYTES_PER_PIXEL = 3'd3,
        CFG_ORIGIN_X        = 3'd4,
        CFG_ORIGIN_Y        = 3'd5
    } cfg_index_t;

    // byte sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW_MAP,
        ST_ROW_WAIT,
        ST_PIX,
        ST_COL_WAIT,
        ST_STEP
    } state_t;

    // handshake between sequencer and divider
    typedef struct packed {
        logic start;
    } div_req_t;

    typedef struct packed {
        logic done;
    } div_rsp_t;

endpackage

// ===== src/bmpscl_div.sv =====
// restoring divider, one quotient bit per cycle
module bmpscl_div import bmpscl_pkg::*; #(
    parameter int DVD_W = 22,
    parameter int DVS_W = 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  div_req_t         req,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output div_rsp_t         rsp,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    // one restoring step
    always_comb begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    // iteration control
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign quotient = quo_reg;

    // done only closes a running division
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    // a start never lands on a running division
    assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");

    // the count runs out exactly when busy falls
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> done_reg && cnt_reg == '0)
        else $error("divider finished with a wrong count");

endmodule

// ===== src/bmp_row_unpack_nearest_scaler_top.sv =====
// bmp pixel byte unpacker with nearest-neighbor downscale onto a fixed screen
// A byte passes through accept, decode and update steps; update waits while a due
// pixel meets a stalled output. The first byte of a row also maps the target row,
// and the red byte of a drawn row that still owes target columns maps its column;
// both go through one shared restoring divider that resolves one quotient bit per cycle.
// A result is registered onto the m_ side in the cycle after its red byte completes.
// aresetn is synchronous, active low: config registers take defaults, counters clear.
module bmp_row_unpack_nearest_scaler_top import bmpscl_pkg::*; #(
    parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH,
    parameter int SCREEN_WIDTH     = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT    = DEF_SCREEN_HEIGHT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration writes
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // input bytes
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    // output pixels
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [23:0] pixel_rgb, [36:24] screen_x,
                                            // [49:37] screen_y, zero above
    output logic                 m_tlast,   // row_end
    output logic [0:0]           m_tuser    // [0] image_end
);

    localparam int EW_W  = $clog2(MAX_SOURCE_WIDTH + 1);
    localparam int EH_W  = $clog2(HEIGHT_LIMIT + 1);
    localparam int ROW_W = $clog2(HEIGHT_LIMIT);
    localparam int COL_W = EW_W;
    localparam int BIR_W = EW_W + 2;
    localparam int TW_W  = $clog2(SCREEN_WIDTH + 1);
    localparam int TH_W  = $clog2(SCREEN_HEIGHT + 1);
    localparam int TR_W  = $clog2(SCREEN_HEIGHT);
    localparam int TC_W  = TW_W;
    localparam int ROW_PROD_W = ROW_W + TH_W;
    localparam int COL_PROD_W = TC_W + EW_W;
    localparam int DVD_W = (ROW_PROD_W > COL_PROD_W) ? ROW_PROD_W : COL_PROD_W;
    localparam int DVS_W = (EH_W > TW_W) ? EH_W : TW_W;
    localparam int PAD_W = M_TDATA_W - M_FIELDS_W;

    // configuration registers
    logic [CFG_W-1:0]   src_w_reg;
    logic [CFG_W-1:0]   src_h_reg;
    logic               top_down_reg;
    logic [BPP_W-1:0]   bpp_reg;
    logic [ORG_X_W-1:0] org_x_reg;
    logic [ORG_Y_W-1:0] org_y_reg;

    // sequencer and image state
    state_t             state_reg, state_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic [1:0]         bip_reg, bip_next;
    logic [BIR_W-1:0]   bir_reg, bir_next;
    logic [COL_W-1:0]   sc_reg, sc_next;
    logic [ROW_W-1:0]   srow_reg, srow_next;
    logic [BYTE_W-1:0]  blue_reg, blue_next;
    logic [BYTE_W-1:0]  green_reg, green_next;
    logic [TC_W-1:0]    ntc_reg, ntc_next;
    logic [TR_W-1:0]    ctr_reg, ctr_next;
    logic               drawn_reg, drawn_next;
    logic [TR_W-1:0]    last_row_reg, last_row_next;
    logic               any_drawn_reg, any_drawn_next;
    logic               emit_reg, emit_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [RGB_W-1:0]   m_rgb_reg, m_rgb_next;
    logic [POS_W-1:0]   m_x_reg, m_x_next;
    logic [POS_W-1:0]   m_y_reg, m_y_next;
    logic               m_row_end_reg, m_row_end_next;
    logic               m_img_end_reg, m_img_end_next;

    // derived image geometry
    logic [EW_W-1:0]    eff_w;
    logic [EH_W-1:0]    eff_h;
    logic               bpp_four;
    logic [EW_W+1:0]    pix_bytes;
    logic [EW_W+1:0]    row_bytes_up;
    logic [BIR_W-1:0]   row_size;
    logic [TW_W-1:0]    tw;
    logic [TH_W-1:0]    th;
    logic               scaled;
    logic [ROW_W-1:0]   srow_fix;
    logic [ROW_W-1:0]   dy;
    logic [TR_W-1:0]    tr_q;
    logic               clipped;
    logic               row_end_c;
    logic               row_last_c;
    logic               out_blocked;

    // divider hookup
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic [DVD_W-1:0]   div_dividend;
    logic [DVS_W-1:0]   div_divisor;
    logic [DVD_W-1:0]   div_quo;

    // configuration write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg    <= CFG_W'(1);
            src_h_reg    <= CFG_W'(1);
            top_down_reg <= 1'b0;
            bpp_reg      <= BPP_W'(3);
            org_x_reg    <= '0;
            org_y_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SOURCE_WIDTH:    src_w_reg    <= cfg_wdata;
                CFG_SOURCE_HEIGHT:   src_h_reg    <= cfg_wdata;
                CFG_ROWS_TOP_DOWN:   top_down_reg <= cfg_wdata[0];
                CFG_BYTES_PER_PIXEL: bpp_reg      <= cfg_wdata[BPP_W-1:0];
                CFG_ORIGIN_X:        org_x_reg    <= cfg_wdata[ORG_X_W-1:0];
                CFG_ORIGIN_Y:        org_y_reg    <= cfg_wdata[ORG_Y_W-1:0];
                default: ;
            endcase
        end
    end

    // saturated width and height, row stride, target size
    always_comb begin
        if (src_w_reg == '0) begin
            eff_w = EW_W'(1);
        end else if (32'(src_w_reg) > MAX_SOURCE_WIDTH) begin
            eff_w = EW_W'(MAX_SOURCE_WIDTH);
        end else begin
            eff_w = EW_W'(src_w_reg);
        end
        if (src_h_reg == '0) begin
            eff_h = EH_W'(1);
        end else if (32'(src_h_reg) > HEIGHT_LIMIT) begin
            eff_h = EH_W'(HEIGHT_LIMIT);
        end else begin
            eff_h = EH_W'(src_h_reg);
        end
        bpp_four     = (bpp_reg == BPP_FOUR);
        pix_bytes    = bpp_four ? {eff_w, 2'b00}
                                : ({1'b0, eff_w, 1'b0} + {2'b00, eff_w});
        row_bytes_up = pix_bytes + (EW_W + 2)'(3);
        row_size     = {row_bytes_up[EW_W+1:2], 2'b00};
        tw     = (32'(eff_w) > SCREEN_WIDTH) ? TW_W'(SCREEN_WIDTH) : TW_W'(eff_w);
        th     = (32'(eff_h) > SCREEN_HEIGHT) ? TH_W'(SCREEN_HEIGHT) : TH_W'(eff_h);
        scaled = (32'(eff_w) > SCREEN_WIDTH) || (32'(eff_h) > SCREEN_HEIGHT);
    end

    // display row of the row being started
    always_comb begin
        srow_fix = (32'(srow_reg) >= 32'(eff_h)) ? '0 : srow_reg;
        dy       = top_down_reg ? srow_fix : ROW_W'(eff_h - EH_W'(1) - EH_W'(srow_fix));
        tr_q     = div_quo[TR_W-1:0];
        clipped  = (32'(org_y_reg) + 32'(tr_q)) >= SCREEN_HEIGHT;
    end

    // end of row and end of image flags for the pixel in flight
    always_comb begin
        row_end_c = (32'(ntc_reg) + 32'd1) >= 32'(tw);
        if (!top_down_reg) begin
            row_last_c = (ctr_reg == '0);
        end else begin
            row_last_c = ((32'(ctr_reg) + 32'd1) >= 32'(th))
                || (scaled && (32'(org_y_reg) + 32'(ctr_reg) + 32'd1) >= SCREEN_HEIGHT);
        end
        out_blocked = m_valid_reg && !m_tready;
    end

    // sequencer: next state and datapath updates
    always_comb begin
        state_next     = state_reg;
        byte_next      = byte_reg;
        bip_next       = bip_reg;
        bir_next       = bir_reg;
        sc_next        = sc_reg;
        srow_next      = srow_reg;
        blue_next      = blue_reg;
        green_next     = green_reg;
        ntc_next       = ntc_reg;
        ctr_next       = ctr_reg;
        drawn_next     = drawn_reg;
        last_row_next  = last_row_reg;
        any_drawn_next = any_drawn_reg;
        emit_next      = emit_reg;
        m_valid_next   = m_valid_reg;
        m_rgb_next     = m_rgb_reg;
        m_x_next       = m_x_reg;
        m_y_next       = m_y_reg;
        m_row_end_next = m_row_end_reg;
        m_img_end_next = m_img_end_reg;
        div_req.start  = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;
        s_tready       = 1'b0;

        // output beat taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    byte_next  = s_tdata[BYTE_W-1:0];
                    state_next = (bir_reg == '0) ? ST_ROW_MAP : ST_PIX;
                end
            end
            // new row: wrap past the last row, then map display row to target row
            ST_ROW_MAP: begin
                if (32'(srow_reg) >= 32'(eff_h)) begin
                    srow_next      = '0;
                    any_drawn_next = 1'b0;
                end
                div_req.start = 1'b1;
                div_dividend  = DVD_W'(dy * th);
                div_divisor   = DVS_W'(eff_h);
                state_next    = ST_ROW_WAIT;
            end
            // target row known: decide drawn, duplicate or clipped
            ST_ROW_WAIT: begin
                if (div_rsp.done) begin
                    if (scaled) begin
                        drawn_next     = !((any_drawn_reg && tr_q == last_row_reg) || clipped);
                        any_drawn_next = 1'b1;
                        last_row_next  = tr_q;
                    end else begin
                        drawn_next = 1'b1;
                    end
                    ctr_next   = tr_q;
                    ntc_next   = '0;
                    state_next = ST_PIX;
                end
            end
            // red byte of a drawn row: find the source column of the next target column; other bytes go to the step
            ST_PIX: begin
                emit_next = 1'b0;
                if ((32'(sc_reg) < 32'(eff_w)) && bip_reg == 2'd2 && drawn_reg
                        && (32'(ntc_reg) < 32'(tw))) begin
                    div_req.start = 1'b1;
                    div_dividend  = DVD_W'(ntc_reg * eff_w);
                    div_divisor   = DVS_W'(tw);
                    state_next    = ST_COL_WAIT;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_COL_WAIT: begin
                if (div_rsp.done) begin
                    emit_next  = (div_quo[COL_W-1:0] == sc_reg);
                    state_next = ST_STEP;
                end
            end
            // emit if due, then advance the byte, pixel and row counters
            ST_STEP: begin
                if (!(emit_reg && out_blocked)) begin
                    if (emit_reg) begin
                        m_valid_next   = 1'b1;
                        m_rgb_next     = {byte_reg, green_reg, blue_reg};
                        m_x_next       = POS_W'(org_x_reg) + POS_W'(ntc_reg);
                        m_y_next       = POS_W'(org_y_reg) + POS_W'(ctr_reg);
                        m_row_end_next = row_end_c;
                        m_img_end_next = row_end_c && row_last_c;
                        ntc_next       = ntc_reg + 1'b1;
                    end
                    if (32'(sc_reg) < 32'(eff_w)) begin
                        if (bip_reg == 2'd0) begin
                            blue_next = byte_reg;
                        end
                        if (bip_reg == 2'd1) begin
                            green_next = byte_reg;
                        end
                        if ((32'(bip_reg) + 32'd1) >= (bpp_four ? 32'd4 : 32'd3)) begin
                            bip_next = '0;
                            sc_next  = sc_reg + 1'b1;
                        end else begin
                            bip_next = bip_reg + 1'b1;
                        end
                    end
                    bir_next = bir_reg + 1'b1;
                    if ((32'(bir_reg) + 32'd1) >= 32'(row_size)) begin
                        bir_next = '0;
                        bip_next = '0;
                        sc_next  = '0;
                        if ((32'(srow_reg) + 32'd1) >= 32'(eff_h)) begin
                            srow_next      = '0;
                            any_drawn_next = 1'b0;
                        end else begin
                            srow_next = srow_reg + 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // image state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bip_reg       <= '0;
            bir_reg       <= '0;
            sc_reg        <= '0;
            srow_reg      <= '0;
            blue_reg      <= '0;
            green_reg     <= '0;
            ntc_reg       <= '0;
            ctr_reg       <= '0;
            drawn_reg     <= 1'b0;
            last_row_reg  <= '0;
            any_drawn_reg <= 1'b0;
            emit_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            bip_reg       <= bip_next;
            bir_reg       <= bir_next;
            sc_reg        <= sc_next;
            srow_reg      <= srow_next;
            blue_reg      <= blue_next;
            green_reg     <= green_next;
            ntc_reg       <= ntc_next;
            ctr_reg       <= ctr_next;
            drawn_reg     <= drawn_next;
            last_row_reg  <= last_row_next;
            any_drawn_reg <= any_drawn_next;
            emit_reg      <= emit_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        byte_reg      <= byte_next;
        m_rgb_reg     <= m_rgb_next;
        m_x_reg       <= m_x_next;
        m_y_reg       <= m_y_next;
        m_row_end_reg <= m_row_end_next;
        m_img_end_reg <= m_img_end_next;
    end

    // shared divider for row and column mapping
    bmpscl_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .rsp      (div_rsp),
        .quotient (div_quo)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_y_reg, m_x_reg, m_rgb_reg};
    assign m_tlast  = m_row_end_reg;
    assign m_tuser  = m_img_end_reg;

    // an accepted byte always leaves idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg != ST_IDLE)
        else $error("accepted byte did not start the sequencer");

    // divider results only arrive while the sequencer waits for them
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_ROW_WAIT || state_reg == ST_COL_WAIT)
        else $error("divider result with no waiting state");

    // a pixel is only loaded for a drawn row
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_STEP && emit_reg |-> drawn_reg)
        else $error("pixel emitted on a row that is not drawn");

    // a pending pixel is never overwritten before it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_STEP && emit_reg && m_valid_reg && !m_tready |=> state_reg == ST_STEP)
        else $error("output register overwritten while stalled");

endmodule
